/* design/sorted_key_table_lookup_macros.svh */
// Assertion macros shared by the sorted key table lookup RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef SORTED_KEY_TABLE_LOOKUP_MACROS_SVH
`define SORTED_KEY_TABLE_LOOKUP_MACROS_SVH
`ifndef ASSERT_OFF
`define SKT_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("sorted key table assertion failed");
`define SKT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sorted key table implication failed");
`else
`define SKT_ASSERT(lbl, ck, rn, prop)
`define SKT_ASSERT_IMP(lbl, ck, rn, ante, cons)
`endif
`endif

/* design/skt_pkg.sv */
// Package for the sorted key table lookup: sizes, mode and status codes, structs.
// Depends on nothing; used by every module of the block.
`default_nettype none
package skt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int HELD_W      = 11;
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 32;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] origin;
    logic [VAL_W-1:0] kind;
    logic [VAL_W-1:0] org;
  } skt_value_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    skt_value_t       val;
  } skt_item_t;

  typedef struct packed {
    logic [1:0]        status;
    skt_value_t        val;
    logic [HELD_W-1:0] held;
  } skt_result_t;

endpackage
`default_nettype wire

/* design/skt_table_mem.sv */
// Entry storage: key and value arrays, one write port, one registered read port.
// Depends on skt_pkg for sizes and the value struct.
`default_nettype none
module skt_table_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [skt_pkg::ADDR_W-1:0] waddr,
  input  wire logic [skt_pkg::KEY_W-1:0]  wkey,
  input  wire skt_pkg::skt_value_t        wval,
  input  wire logic [skt_pkg::ADDR_W-1:0] raddr,
  output logic      [skt_pkg::KEY_W-1:0]  rkey,
  output skt_pkg::skt_value_t             rval
);

  logic [skt_pkg::KEY_W-1:0] key_mem [skt_pkg::TABLE_DEPTH];
  skt_pkg::skt_value_t       val_mem [skt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule
`default_nettype wire

/* design/skt_seq.sv */
// Sequencer for the table: binary search, append order check, clear, with one
// shared 64-bit key comparator. Depends on skt_pkg and drives skt_table_mem.
`default_nettype none
module skt_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire skt_pkg::skt_item_t         item,
  output logic                            idle,
  output logic                            res_valid,
  input  wire logic                       res_take,
  output skt_pkg::skt_result_t            res,
  output logic                            mem_we,
  output logic      [skt_pkg::ADDR_W-1:0] mem_waddr,
  output logic      [skt_pkg::KEY_W-1:0]  mem_wkey,
  output skt_pkg::skt_value_t             mem_wval,
  output logic      [skt_pkg::ADDR_W-1:0] mem_raddr,
  input  wire logic [skt_pkg::KEY_W-1:0]  mem_rkey,
  input  wire skt_pkg::skt_value_t        mem_rval
);

  localparam int ADDR_W = skt_pkg::ADDR_W;
  localparam int CNT_W  = skt_pkg::CNT_W;
  localparam int HELD_W = skt_pkg::HELD_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_APPCHK = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  skt_pkg::skt_item_t   item_r, item_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    mid_r;
  skt_pkg::skt_result_t res_r, res_nxt;

  logic                 key_eq, key_lt;
  logic                 finish;
  logic [1:0]           f_status;
  skt_pkg::skt_value_t  f_val;
  logic [CNT_W-1:0]     lo_up, mid_ext;
  logic [CNT_W:0]       span_sum;
  logic [CNT_W+HELD_W-1:0] held_ext;

  // The shared comparator: probe word from memory against the item's key.
  assign key_eq = (mem_rkey == item_r.key);
  assign key_lt = (mem_rkey <  item_r.key);

  assign mid_ext  = {{(CNT_W-ADDR_W){1'b0}}, mid_r};
  assign lo_up    = mid_ext + CNT_W'(1);
  assign held_ext = {{HELD_W{1'b0}}, cnt_nxt};

  assign mem_waddr = cnt_r[ADDR_W-1:0];
  assign mem_wkey  = (state_r == S_IDLE) ? item.key : item_r.key;
  assign mem_wval  = (state_r == S_IDLE) ? item.val : item_r.val;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    mem_raddr = mid_r;
    mem_we    = 1'b0;
    finish    = 1'b0;
    f_status  = skt_pkg::ST_MISS;
    f_val     = '0;
    span_sum  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = item;
          case (item.mode)
            skt_pkg::MODE_LOOKUP: begin
              if (cnt_r == '0) begin
                finish = 1'b1;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = cnt_r;
                mem_raddr = ADDR_W'(cnt_r >> 1);
                state_nxt = S_SEARCH;
              end
            end
            skt_pkg::MODE_APPEND: begin
              if (cnt_r >= CNT_W'(skt_pkg::TABLE_DEPTH)) begin
                finish   = 1'b1;
                f_status = skt_pkg::ST_FULL;
              end else if (cnt_r == '0) begin
                mem_we   = 1'b1;
                cnt_nxt  = cnt_r + CNT_W'(1);
                finish   = 1'b1;
                f_status = skt_pkg::ST_OK;
              end else begin
                // Fetch the last key held to check the order next cycle.
                mem_raddr = ADDR_W'(cnt_r - CNT_W'(1));
                state_nxt = S_APPCHK;
              end
            end
            skt_pkg::MODE_CLEAR: begin
              cnt_nxt  = '0;
              finish   = 1'b1;
              f_status = skt_pkg::ST_OK;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (key_eq) begin
          finish   = 1'b1;
          f_status = skt_pkg::ST_OK;
          f_val    = mem_rval;
        end else begin
          if (key_lt) begin
            lo_nxt = lo_up;
          end else begin
            hi_nxt = mid_ext;
          end
          if (lo_nxt >= hi_nxt) begin
            finish = 1'b1;
          end else begin
            // Next probe address goes straight to the memory so that one
            // probe completes every cycle.
            span_sum  = {1'b0, lo_nxt} + {1'b0, hi_nxt};
            mem_raddr = span_sum[ADDR_W:1];
          end
        end
      end
      S_APPCHK: begin
        finish = 1'b1;
        if (!key_lt) begin
          f_status = skt_pkg::ST_ORDER;
        end else begin
          mem_we   = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          f_status = skt_pkg::ST_OK;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (finish) begin
      state_nxt      = S_DONE;
      res_nxt.status = f_status;
      res_nxt.val    = f_val;
      res_nxt.held   = held_ext[HELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mem_raddr;
    res_r  <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule
`default_nettype wire

/* design/sorted_key_table_lookup.sv */
// Top level of the sorted key table lookup: handshakes and the output register.
// Depends on skt_pkg, skt_seq, skt_table_mem and the assertion macro header.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    mode, device key, three values
//   out_     output     out_valid / out_ready  status, three found values, entries held
//
// A lookup makes at most 11 probes for 1024 entries: one memory read per probe feeding
// the shared key comparator. Append first reads the last key held to check the order,
// unless the table is empty or full.
// Reset empties the table; the key and value memories are not cleared.
// A finished result waits in the output register while the next item is taken;
// the sequencer stalls in its done state only if that register is still full.
`default_nettype none
`include "sorted_key_table_lookup_macros.svh"
module sorted_key_table_lookup (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_device_key,
  input  wire logic [31:0] in_origin_value,
  input  wire logic [31:0] in_origin_kind,
  input  wire logic [31:0] in_org_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_origin,
  output logic [31:0]      out_found_kind,
  output logic [31:0]      out_found_org,
  output logic [10:0]      out_entries_held
);

  skt_pkg::skt_item_t   item;
  skt_pkg::skt_result_t res;
  skt_pkg::skt_result_t out_r;
  logic                 out_valid_r;
  logic                 seq_idle, res_valid, res_take, start;

  logic                          mem_we;
  logic [skt_pkg::ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [skt_pkg::KEY_W-1:0]     mem_wkey, mem_rkey;
  skt_pkg::skt_value_t           mem_wval, mem_rval;

  assign item.mode       = in_mode;
  assign item.key        = in_device_key;
  assign item.val.origin = in_origin_value;
  assign item.val.kind   = in_origin_kind;
  assign item.val.org    = in_org_value;

  assign in_ready = seq_idle;
  assign start    = in_valid && seq_idle;
  assign res_take = !out_valid_r || out_ready;

  skt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wkey  (mem_wkey),
    .mem_wval  (mem_wval),
    .mem_raddr (mem_raddr),
    .mem_rkey  (mem_rkey),
    .mem_rval  (mem_rval)
  );

  skt_table_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (mem_wkey),
    .wval  (mem_wval),
    .raddr (mem_raddr),
    .rkey  (mem_rkey),
    .rval  (mem_rval)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_found_origin = out_r.val.origin;
  assign out_found_kind   = out_r.val.kind;
  assign out_found_org    = out_r.val.org;
  assign out_entries_held = out_r.held;

  // An accepted item always leaves the sequencer busy in the next cycle.
  `SKT_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  // Only a successful lookup carries values.
  `SKT_ASSERT_IMP(a_miss_no_values, clk, rst_n, res_valid && res.status != skt_pkg::ST_OK, res.val == '0)
  // The held count never exceeds the table depth.
  `SKT_ASSERT_IMP(a_held_in_range, clk, rst_n, res_valid, 32'(res.held) <= 32'(skt_pkg::TABLE_DEPTH))
  // A result is only handed over when the output register can take it.
  `SKT_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready && res_valid, ##1 res_valid)

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_table_lookup: directed table, a full-table pass and
// random traffic, scored against a shadow copy of the sorted table or a typed expected result. Needs skt_pkg.
module testbench;
  import skt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 40;
  localparam int unsigned BACKPRESSURE_AT = 300;
  localparam int unsigned BACKPRESSURE_LEN = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam skt_value_t VAL_A = 96'h0123_4567_89AB_CDEF_DEAD_BEEF;
  localparam skt_value_t VAL_B = 96'hA5A5_5A5A_0000_0001_8000_0000;
  localparam skt_value_t VAL_C = 96'h7FFF_FFFF_FFFF_0000_0000_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_LOOKUP;
  logic [63:0] in_device_key = '0;
  logic [31:0] in_origin_value = '0;
  logic [31:0] in_origin_kind = '0;
  logic [31:0] in_org_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_found_origin;
  logic [31:0] out_found_kind;
  logic [31:0] out_found_org;
  logic [10:0] out_entries_held;

  sorted_key_table_lookup u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_device_key    (in_device_key),
    .in_origin_value  (in_origin_value),
    .in_origin_kind   (in_origin_kind),
    .in_org_value     (in_org_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_origin (out_found_origin),
    .out_found_kind   (out_found_kind),
    .out_found_org    (out_found_org),
    .out_entries_held (out_entries_held)
  );

  always #5 clk = ~clk;

  // Shadow of the table contents, updated as each input transfer completes.
  logic [63:0]  shadow_key [TABLE_DEPTH];
  skt_value_t   shadow_val [TABLE_DEPTH];
  int unsigned  shadow_count = 0;
  skt_result_t  awaited_results [$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycle_count = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  typedef struct {
    skt_item_t   item;
    bit          typed;
    skt_result_t want;
  } dir_row_t;

  // Rows with typed = 1 carry their expected result; the rest use the shadow table.
  dir_row_t dir_rows [23] = '{
    '{'{MODE_LOOKUP, 64'd0, '1},                   1'b1, '{ST_MISS, '0, 11'd0}},
    '{'{MODE_LOOKUP, KEY_MAX, '0},                 1'b1, '{ST_MISS, '0, 11'd0}},
    '{'{MODE_UNUSED, KEY_MAX, '1},                 1'b1, '{ST_MISS, '0, 11'd0}},
    '{'{MODE_CLEAR, 64'd0, '1},                    1'b1, '{ST_OK, '0, 11'd0}},
    '{'{MODE_APPEND, 64'd0, '1},                   1'b1, '{ST_OK, '0, 11'd1}},
    '{'{MODE_APPEND, 64'd0, VAL_A},                1'b1, '{ST_ORDER, '0, 11'd1}},
    '{'{MODE_LOOKUP, 64'd0, '0},                   1'b1, '{ST_OK, '1, 11'd1}},
    '{'{MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, VAL_A}, 1'b0, '0},
    '{'{MODE_APPEND, 64'h8000_0000_0000_0000, VAL_B}, 1'b0, '0},
    '{'{MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFE, VAL_C}, 1'b1, '{ST_ORDER, '0, 11'd3}},
    '{'{MODE_APPEND, 64'h8000_0000_0000_0000, VAL_C}, 1'b1, '{ST_ORDER, '0, 11'd3}},
    '{'{MODE_APPEND, KEY_MAX, VAL_C},              1'b0, '0},
    '{'{MODE_APPEND, KEY_MAX, VAL_A},              1'b1, '{ST_ORDER, '0, 11'd4}},
    '{'{MODE_UNUSED, 64'd5, VAL_A},                1'b1, '{ST_MISS, '0, 11'd4}},
    '{'{MODE_LOOKUP, 64'h8000_0000_0000_0000, '1}, 1'b0, '0},
    '{'{MODE_LOOKUP, KEY_MAX, '0},                 1'b0, '0},
    '{'{MODE_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0}, 1'b0, '0},
    '{'{MODE_LOOKUP, 64'h8000_0000_0000_0001, '0}, 1'b1, '{ST_MISS, '0, 11'd4}},
    '{'{MODE_LOOKUP, 64'd1, '1},                   1'b1, '{ST_MISS, '0, 11'd4}},
    '{'{MODE_CLEAR, KEY_MAX, VAL_B},               1'b1, '{ST_OK, '0, 11'd0}},
    '{'{MODE_LOOKUP, KEY_MAX, '0},                 1'b1, '{ST_MISS, '0, 11'd0}},
    '{'{MODE_APPEND, 64'd5, VAL_B},                1'b1, '{ST_OK, '0, 11'd1}},
    '{'{MODE_LOOKUP, 64'd5, '0},                   1'b0, '0}
  };

  function automatic skt_result_t apply_to_shadow_table(input skt_item_t it);
    skt_result_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit hit;
    r = '0;
    r.status = ST_MISS;
    case (it.mode)
      MODE_LOOKUP: begin
        lo = 0;
        hi = shadow_count;
        hit = 1'b0;
        while (!hit && lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_key[mid] == it.key) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.val = shadow_val[mid];
          end else if (shadow_key[mid] < it.key) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
      end
      MODE_APPEND: begin
        // A full table rejects the key before its order is looked at.
        if (shadow_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (shadow_count > 0 && shadow_key[shadow_count - 1] >= it.key) begin
          r.status = ST_ORDER;
        end else begin
          shadow_key[shadow_count] = it.key;
          shadow_val[shadow_count] = it.val;
          shadow_count++;
          r.status = ST_OK;
        end
      end
      MODE_CLEAR: begin
        shadow_count = 0;
        r.status = ST_OK;
      end
      default: ;
    endcase
    r.held = HELD_W'(shadow_count);
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly keys that are held, some neighbors of held keys and some at random.
  function automatic logic [63:0] probe_key();
    logic [63:0] k;
    int unsigned p;
    if (shadow_count == 0) return {$urandom, $urandom};
    k = shadow_key[$urandom_range(0, shadow_count - 1)];
    p = $urandom_range(0, 9);
    if (p < 7) return k;
    if (p == 7) return k + 64'd1;
    if (p == 8) return k - 64'd1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] append_key();
    logic [63:0] last;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (shadow_count == 0) begin
      if (p < 10) return KEY_MAX - 64'($urandom_range(0, 2));
      if (p < 40) return {32'd0, $urandom};
      return {$urandom, $urandom};
    end
    last = shadow_key[shadow_count - 1];
    if (p < 40) return last + 64'($urandom_range(1, 4));
    if (p < 70) return last + {32'd0, $urandom};
    if (p < 88) return last + {8'd0, 24'($urandom), $urandom};
    if (p < 94) return last;
    return last - 64'($urandom_range(1, 1000));
  endfunction

  function automatic skt_item_t random_item();
    skt_item_t it;
    int unsigned p;
    it.val = {$urandom, $urandom, $urandom};
    p = $urandom_range(0, 99);
    if (p < 45) begin
      it.mode = MODE_LOOKUP;
      it.key = probe_key();
    end else if (p < 95) begin
      it.mode = MODE_APPEND;
      it.key = append_key();
    end else if (p < 98) begin
      it.mode = MODE_CLEAR;
      it.key = {$urandom, $urandom};
    end else begin
      it.mode = MODE_UNUSED;
      it.key = probe_key();
    end
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer completes.
  task automatic push_item(input skt_item_t it, input bit typed, input skt_result_t want);
    int unsigned gap;
    skt_result_t predicted;
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= it.mode;
    in_device_key   <= it.key;
    in_origin_value <= it.val.origin;
    in_origin_kind  <= it.val.kind;
    in_org_value    <= it.val.org;
    do @(posedge clk); while (!in_ready);
    predicted = apply_to_shadow_table(it);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Clears and fills the table to capacity with lookups mixed in, knocks on the full table, probes it and clears it.
  task automatic fill_to_capacity();
    skt_item_t it;
    logic [63:0] next_key;
    it = '{MODE_CLEAR, 64'd0, '0};
    push_item(it, 1'b0, '0);
    next_key = {32'd0, $urandom};
    while (shadow_count < TABLE_DEPTH) begin
      it.val = {$urandom, $urandom, $urandom};
      if (shadow_count > 0 && $urandom_range(0, 31) == 0) begin
        it.mode = MODE_LOOKUP;
        it.key = probe_key();
      end else begin
        it.mode = MODE_APPEND;
        it.key = next_key;
        next_key = next_key + 64'd1 + 64'($urandom_range(0, 1 << 20));
      end
      push_item(it, 1'b0, '0);
    end
    it = '{MODE_APPEND, next_key, VAL_A};
    push_item(it, 1'b1, '{ST_FULL, '0, 11'd1024});
    it = '{MODE_APPEND, 64'd0, VAL_B};
    push_item(it, 1'b1, '{ST_FULL, '0, 11'd1024});
    repeat (10) begin
      it = '{MODE_LOOKUP, probe_key(), '0};
      push_item(it, 1'b0, '0);
    end
    it = '{MODE_CLEAR, 64'd0, '0};
    push_item(it, 1'b1, '{ST_OK, '0, 11'd0});
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic score_result();
    skt_result_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: result with no transfer pending, expected none, got status %0d",
                 $time, out_status);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", want.status, out_status);
    compare_field("found_origin", want.val.origin, out_found_origin);
    compare_field("found_kind", want.val.kind, out_found_kind);
    compare_field("found_org", want.val.org, out_found_org);
    compare_field("entries_held", want.held, out_entries_held);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, calm stretches, and one long hold-off that backs up
  // the block so its input stalls while items are still offered.
  initial begin
    int unsigned hold_left;
    bit pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        score_result();
        results_seen++;
      end
      if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
      if (!pressure_done && results_seen >= BACKPRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left = BACKPRESSURE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_burst && $urandom_range(0, 3) == 0) hold_left = idle_len();
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    repeat (RANDOM_ITEMS) push_item(random_item(), 1'b0, '0);
    fill_to_capacity();
    repeat (RANDOM_ITEMS) push_item(random_item(), 1'b0, '0);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/skt_pkg.sv
design/skt_table_mem.sv
design/skt_seq.sv
design/sorted_key_table_lookup.sv
bench/testbench.sv
